>>> rtl/slkpd_pkg.sv
// Shared constants for the short/long key press detector.
// No dependencies; used by short_long_key_press_detector.
package slkpd_pkg;

	localparam int NUM_KEYS    = 2;
	localparam int TIMER_WIDTH = 16;

	// fixed widths of the ports
	localparam int FIELD_W = 2;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 1;

	// widths used inside the step logic
	localparam int PIN_W = (NUM_KEYS > FIELD_W) ? NUM_KEYS : FIELD_W;
	localparam int CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

	localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

	localparam logic [CFG_W-1:0] LOCKOUT_RESET = CFG_W'(100);
	localparam logic [CFG_W-1:0] LONG_RESET    = CFG_W'(500);

	typedef enum logic [IDX_W-1:0] {
		REG_LOCKOUT    = 1'b0,
		REG_LONG_PRESS = 1'b1
	} reg_idx_t;

endpackage

>>> rtl/short_long_key_press_detector.sv
// Short/long key press detector: top level, one module.
// Depends on slkpd_pkg for sizes, reset values and register indexes.
//
// Usage:
//   Input channel (in_valid/in_ready, key_pins): one request per millisecond
//   tick, carrying the active-low key pins. Output channel (out_valid/
//   out_ready): one result per tick with short_events, long_events and the
//   debounced held_mask.
//   A request is first captured in an input register, then the tick is
//   evaluated in one pass (counter increment, keys in index order) as it
//   moves into the result register, which drives out_valid; one request
//   per cycle is sustained while out_ready is high. The evaluation is done
//   when the request leaves the input stage, so the shared counter and key
//   state are never ahead of the result. When the receiver stalls, the
//   result waits in the output register and one more request is still
//   taken into the input register; after that in_ready drops until the
//   result is taken. Registers lockout_ms (index 0) and long_press_ms
//   (index 1) are written through wr_en/wr_index/wr_data; the user must
//   write them only while no request is in flight, and the block does
//   not enforce this.
//   Reset (arst_n low) empties both stages, clears the counter and the key
//   state, and loads lockout 100 and long press 500.
module short_long_key_press_detector (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [slkpd_pkg::IDX_W-1:0]  wr_index,
	input  logic [slkpd_pkg::CFG_W-1:0]  wr_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [slkpd_pkg::FIELD_W-1:0] key_pins,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [slkpd_pkg::FIELD_W-1:0] short_events,
	output logic [slkpd_pkg::FIELD_W-1:0] long_events,
	output logic [slkpd_pkg::FIELD_W-1:0] held_mask
);

	localparam int NK  = slkpd_pkg::NUM_KEYS;
	localparam int TW  = slkpd_pkg::TIMER_WIDTH;
	localparam int FW  = slkpd_pkg::FIELD_W;
	localparam int PW  = slkpd_pkg::PIN_W;
	localparam int CW  = slkpd_pkg::CMP_W;

	logic [slkpd_pkg::CFG_W-1:0] lockout_q;
	logic [slkpd_pkg::CFG_W-1:0] long_press_q;
	logic [TW-1:0]               elapsed_q;
	logic [NK-1:0]               key_held_q;
	logic [NK-1:0]               long_fired_q;

	logic          valid_s1;
	logic [FW-1:0] key_pins_s1;
	logic          out_valid_q;
	logic [FW-1:0] short_q;
	logic [FW-1:0] long_q;
	logic [FW-1:0] held_q;

	logic advance;

	// step logic results
	logic [TW-1:0] elapsed_nxt;
	logic [NK-1:0] key_held_nxt;
	logic [NK-1:0] long_fired_nxt;
	logic [PW-1:0] short_vec;
	logic [PW-1:0] long_vec;
	logic [PW-1:0] held_vec;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lockout_q    <= slkpd_pkg::LOCKOUT_RESET;
			long_press_q <= slkpd_pkg::LONG_RESET;
		end else if (wr_en) begin
			case (slkpd_pkg::reg_idx_t'(wr_index))
				slkpd_pkg::REG_LOCKOUT:    lockout_q    <= wr_data;
				slkpd_pkg::REG_LONG_PRESS: long_press_q <= wr_data;
				default: ;
			endcase
		end
	end

	// one tick: keys in index order share the running counter value
	always_comb begin
		logic [TW-1:0] e;
		logic [PW-1:0] pins;
		logic          down;
		e              = (elapsed_q != slkpd_pkg::TIMER_MAX) ? elapsed_q + 1'b1 : elapsed_q;
		pins           = PW'(key_pins_s1);
		key_held_nxt   = key_held_q;
		long_fired_nxt = long_fired_q;
		short_vec      = '0;
		long_vec       = '0;
		held_vec       = '0;
		for (int i = 0; i < NK; i++) begin
			down = !pins[i];
			if (CW'(e) >= CW'(lockout_q)) begin
				if (key_held_nxt[i]) begin
					if ((CW'(e) > CW'(long_press_q)) && !long_fired_nxt[i]) begin
						long_vec[i]       = 1'b1;
						long_fired_nxt[i] = 1'b1;
					end else if (!down) begin
						key_held_nxt[i]   = 1'b0;
						e                 = '0;
						short_vec[i]      = !long_fired_nxt[i];
						long_fired_nxt[i] = 1'b0;
					end
				end else if (down) begin
					key_held_nxt[i] = 1'b1;
					e               = '0;
				end
			end
		end
		held_vec    = PW'(key_held_nxt);
		elapsed_nxt = e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q    <= '0;
			key_held_q   <= '0;
			long_fired_q <= '0;
		end else if (advance) begin
			elapsed_q    <= elapsed_nxt;
			key_held_q   <= key_held_nxt;
			long_fired_q <= long_fired_nxt;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			key_pins_s1 <= key_pins;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			short_q <= short_vec[FW-1:0];
			long_q  <= long_vec[FW-1:0];
			held_q  <= held_vec[FW-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign short_events = short_q;
	assign long_events  = long_q;
	assign held_mask    = held_q;

	// a long press is only ever pending on a held key
	a_fired_needs_held: assert property (@(posedge clk) disable iff (!arst_n)
		(long_fired_q & ~key_held_q) == '0)
		else $error("long_fired set on a key that is not held");

	// a shown result carries the key state left by its own tick
	a_held_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (held_q == FW'(PW'(key_held_q))))
		else $error("held_mask differs from key state");

	a_no_double_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((short_q & long_q) == '0))
		else $error("short and long press on the same key in one tick");

	a_short_released: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((short_q & held_q) == '0 && (long_q & ~held_q) == '0))
		else $error("event inconsistent with held state");

endmodule
